@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the key/payload sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SKS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SKS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sks_pkg.sv @@
// Package with the types and constants of the key/payload sorter.
`default_nettype none

package sks_pkg;

  localparam int SKS_MAX_ENTRIES = 64;
  localparam int QID_W           = 4;
  localparam int KEY_W           = 32;
  localparam int PAYLOAD_W       = 32;

  // One stored entry of the sorting chain.
  typedef struct packed {
    logic                 valid;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } sks_entry_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic                 insert;
    logic                 shift;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } sks_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } sks_state_t;

endpackage

`default_nettype wire

@@ rtl/sks_in_if.sv @@
// Valid/ready interface that carries one input entry of the sorter.
`default_nettype none

interface sks_in_if import sks_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [QID_W-1:0]     queue_id;
  logic [KEY_W-1:0]     sort_key;
  logic [PAYLOAD_W-1:0] payload;
  logic                 last;

  modport source (output valid, output queue_id, output sort_key, output payload,
                  output last, input ready);
  modport sink   (input valid, input queue_id, input sort_key, input payload,
                  input last, output ready);
endinterface

`default_nettype wire

@@ rtl/sks_out_if.sv @@
// Valid/ready interface that carries one sorted result of the sorter.
`default_nettype none

interface sks_out_if import sks_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [QID_W-1:0]     queue_id_out;
  logic [KEY_W-1:0]     sorted_key;
  logic [PAYLOAD_W-1:0] sorted_payload;
  logic                 last_out;
  logic                 dropped;

  modport source (output valid, output queue_id_out, output sorted_key,
                  output sorted_payload, output last_out, output dropped, input ready);
  modport sink   (input valid, input queue_id_out, input sorted_key,
                  input sorted_payload, input last_out, input dropped, output ready);
endinterface

`default_nettype wire

@@ rtl/sks_cell.sv @@
// One cell of the insertion sorting chain.
`default_nettype none

module sks_cell import sks_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire sks_ctl_t   ctl,
  input  wire sks_entry_t prev_ent,
  input  wire logic       prev_gt,
  input  wire sks_entry_t next_ent,
  output sks_entry_t      ent_o,
  output logic            gt_o
);

  logic                 valid_r, valid_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [PAYLOAD_W-1:0] payload_r, payload_nxt;

  assign ent_o = '{valid: valid_r, key: key_r, payload: payload_r};
  // Strictly greater keeps equal keys in arrival order.
  assign gt_o  = valid_r && (key_r > ctl.key);

  always_comb begin
    valid_nxt   = valid_r;
    key_nxt     = key_r;
    payload_nxt = payload_r;
    if (ctl.shift) begin
      valid_nxt   = next_ent.valid;
      key_nxt     = next_ent.key;
      payload_nxt = next_ent.payload;
    end else if (ctl.insert) begin
      if (prev_gt) begin
        valid_nxt   = prev_ent.valid;
        key_nxt     = prev_ent.key;
        payload_nxt = prev_ent.payload;
      end else if (prev_ent.valid && (!valid_r || gt_o)) begin
        valid_nxt   = 1'b1;
        key_nxt     = ctl.key;
        payload_nxt = ctl.payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/stable_key_payload_sorter_core.sv @@
// Throughput: one entry per cycle while loading; results drain at one per cycle while
// the output is free or accepted. The first result is registered after the state
// machine enters drain on the transfer that carries last; n stored entries give n
// results. No input is taken while a run drains; the next queue may start once the final
// result sits in the output register. Synchronous active-low reset empties the chain.
`default_nettype none
`include "assert_macros.svh"

module stable_key_payload_sorter_core import sks_pkg::*; #(
  parameter int MAX_ENTRIES = SKS_MAX_ENTRIES
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sks_in_if.sink    in_ch,
  sks_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  // Controller state.
  sks_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             overflow_r, overflow_nxt;
  logic [QID_W-1:0] qid_r, qid_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  logic [QID_W-1:0]     out_qid_r;
  logic [KEY_W-1:0]     out_key_r;
  logic [PAYLOAD_W-1:0] out_payload_r;
  logic                 out_last_r;
  logic                 out_dropped_r;

  logic     in_xfer;
  logic     full;
  logic     do_insert;
  logic     load_out;
  logic     final_load;
  sks_ctl_t ctl;

  sks_entry_t             ent [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] gt;
  logic [MAX_ENTRIES-1:0] valid_vec;

  assign in_xfer    = in_ch.valid && in_ch.ready;
  assign full       = (count_r == FULL_CNT);
  // An entry that arrives with the chain full is discarded and flagged.
  assign do_insert  = in_xfer && !full;
  // During a drain, the head cell moves into the output register whenever it is free.
  assign load_out   = (state_r == ST_DRAIN) && (!out_valid_r || out_ch.ready);
  assign final_load = load_out && (count_r == ONE_CNT);

  assign ctl = '{insert: do_insert, shift: load_out,
                 key: in_ch.sort_key, payload: in_ch.payload};

  // The chain: each cell compares the broadcast key with its own, takes its lower
  // neighbor's entry when that neighbor is greater, or takes the new entry at the
  // boundary. On each drain shift, every cell takes its upper neighbor's entry.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    sks_entry_t prev_ent;
    logic       prev_gt;
    sks_entry_t next_ent;

    if (i == 0) begin : g_head
      assign prev_ent = '{valid: 1'b1, key: '0, payload: '0};
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_ent = ent[i-1];
      assign prev_gt  = gt[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = ent[i+1];
    end

    sks_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .prev_ent (prev_ent),
      .prev_gt  (prev_gt),
      .next_ent (next_ent),
      .ent_o    (ent[i]),
      .gt_o     (gt[i])
    );

    assign valid_vec[i] = ent[i].valid;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_xfer && in_ch.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (final_load) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Output logic of the state machine.
  always_comb begin
    case (state_r)
      ST_LOAD:  in_ch.ready = 1'b1;
      ST_DRAIN: in_ch.ready = 1'b0;
      default:  in_ch.ready = 1'b0;
    endcase
  end

  // Occupancy, overflow flag and the queue slot of the item that ends the queue.
  always_comb begin
    count_nxt    = count_r;
    overflow_nxt = overflow_r;
    qid_nxt      = qid_r;
    if (do_insert) begin
      count_nxt = count_r + ONE_CNT;
    end else if (load_out) begin
      count_nxt = count_r - ONE_CNT;
    end
    if (in_xfer && full) begin
      overflow_nxt = 1'b1;
    end else if (final_load) begin
      overflow_nxt = 1'b0;
    end
    if (in_xfer && in_ch.last) begin
      qid_nxt = in_ch.queue_id;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    qid_r <= qid_nxt;
    if (load_out) begin
      out_qid_r     <= qid_r;
      out_key_r     <= ent[0].key;
      out_payload_r <= ent[0].payload;
      out_last_r    <= (count_r == ONE_CNT);
      out_dropped_r <= overflow_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.queue_id_out   = out_qid_r;
  assign out_ch.sorted_key     = out_key_r;
  assign out_ch.sorted_payload = out_payload_r;
  assign out_ch.last_out       = out_last_r;
  assign out_ch.dropped        = out_dropped_r;

  // The number of occupied cells always equals the count.
  `SKS_ASSERT_NOW(a_occupancy_matches, 1'b1, $countones(valid_vec) == count_r,
    "chain occupancy disagrees with entry count")
  `SKS_ASSERT_NOW(a_count_bounded, 1'b1, count_r <= FULL_CNT,
    "entry count beyond capacity")
  // Handing over the final result of a run leaves the block empty and loading.
  `SKS_ASSERT_NEXT(a_run_ends_clean, final_load,
    (count_r == '0) && !overflow_r && (state_r == ST_LOAD) && out_ch.last_out,
    "run did not end cleanly")
  // The two head cells stay in ascending key order when both are occupied.
  `SKS_ASSERT_NOW(a_head_ordered, ent[1].valid, ent[0].key <= ent[1].key,
    "head cells out of order")

endmodule

`default_nettype wire
